// File: hdl/cctp_pkg.sv
// Shared constants and the arctangent table for the centered Cartesian-to-polar block.
`default_nettype none
package cctp_pkg;

    // Fixed field and register widths.
    localparam int FIELD_BITS = 16;
    localparam int CFG_BITS   = 13;
    localparam int ATAN_BITS  = 32;

    // Register indexes of the configuration port.
    localparam logic CFG_IDX_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_IDX_FRAME_HEIGHT = 1'b1;

    // Register reset values and the legal frame size range.
    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;
    localparam logic [CFG_BITS-1:0] FRAME_SIZE_MIN     = 13'd2;
    localparam logic [CFG_BITS-1:0] FRAME_SIZE_MAX     = 13'd4096;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic [ATAN_BITS-1:0] atan_turn32(input int idx);
        logic [ATAN_BITS-1:0] e;
        case (idx)
            0:       e = 32'h20000000;
            1:       e = 32'h12E4051E;
            2:       e = 32'h09FB385B;
            3:       e = 32'h051111D4;
            4:       e = 32'h028B0D43;
            5:       e = 32'h0145D7E1;
            6:       e = 32'h00A2F61E;
            7:       e = 32'h00517C55;
            8:       e = 32'h0028BE53;
            9:       e = 32'h00145F2F;
            10:      e = 32'h000A2F98;
            11:      e = 32'h000517CC;
            12:      e = 32'h00028BE6;
            13:      e = 32'h000145F3;
            14:      e = 32'h0000A2F9;
            15:      e = 32'h0000517C;
            16:      e = 32'h000028BE;
            17:      e = 32'h0000145F;
            18:      e = 32'h00000A2F;
            19:      e = 32'h00000517;
            20:      e = 32'h0000028B;
            21:      e = 32'h00000145;
            22:      e = 32'h000000A2;
            23:      e = 32'h00000051;
            default: e = 32'h00000000;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// File: hdl/cctp_cordic_cell.sv
// One vectoring CORDIC cell: rotates the offset and the half-diagonal by one micro-angle.
`default_nettype none
module cctp_cordic_cell #(
    parameter int IDX = 0,
    parameter int DW  = 20,
    parameter int AB  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [DW-1:0] in_x,
    input  wire logic signed [DW-1:0] in_y,
    input  wire logic        [AB-1:0] in_z,
    input  wire logic signed [DW-1:0] in_xc,
    input  wire logic signed [DW-1:0] in_yc,
    input  wire logic                 in_zero,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [DW-1:0]      out_x,
    output logic signed [DW-1:0]      out_y,
    output logic        [AB-1:0]      out_z,
    output logic signed [DW-1:0]      out_xc,
    output logic signed [DW-1:0]      out_yc,
    output logic                      out_zero
);

    // Micro-angle of this cell, rounded half up to AB bits.
    localparam int SH = cctp_pkg::ATAN_BITS - AB;
    localparam logic [cctp_pkg::ATAN_BITS:0] ATAN_E = {1'b0, cctp_pkg::atan_turn32(IDX)};
    localparam logic [cctp_pkg::ATAN_BITS:0] ATAN_R =
        (ATAN_E + ({{cctp_pkg::ATAN_BITS{1'b0}}, 1'b1} << (SH - 1))) >> SH;
    localparam logic [AB-1:0] STEP = ATAN_R[AB-1:0];

    logic                 valid_reg;
    logic signed [DW-1:0] x_reg, y_reg, xc_reg, yc_reg;
    logic        [AB-1:0] z_reg;
    logic                 zero_reg;
    logic signed [DW-1:0] x_next, y_next, xc_next, yc_next;
    logic        [AB-1:0] z_next;

    // Rotation toward the x axis for both vectors.
    always_comb
    begin
        if (!in_y[DW-1])
        begin
            x_next = in_x + (in_y >>> IDX);
            y_next = in_y - (in_x >>> IDX);
            z_next = in_z + STEP;
        end
        else
        begin
            x_next = in_x - (in_y >>> IDX);
            y_next = in_y + (in_x >>> IDX);
            z_next = in_z - STEP;
        end
        if (!in_yc[DW-1])
        begin
            xc_next = in_xc + (in_yc >>> IDX);
            yc_next = in_yc - (in_xc >>> IDX);
        end
        else
        begin
            xc_next = in_xc - (in_yc >>> IDX);
            yc_next = in_yc + (in_xc >>> IDX);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Cell register with handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            xc_reg   <= xc_next;
            yc_reg   <= yc_next;
            zero_reg <= in_zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_xc    = xc_reg;
    assign out_yc    = yc_reg;
    assign out_zero  = zero_reg;

endmodule
`default_nettype wire

// File: hdl/cctp_div_cell.sv
// One restoring division cell: produces one quotient bit of the distance ratio.
`default_nettype none
module cctp_div_cell #(
    parameter int DW = 20
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [DW:0]    in_rem,
    input  wire logic [15:0]    in_nlow,
    input  wire logic [15:0]    in_quot,
    input  wire logic [DW-1:0]  in_den,
    input  wire logic [15:0]    in_bear,
    input  wire logic           in_sat,
    input  wire logic           in_zero,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [DW:0]         out_rem,
    output logic [15:0]         out_nlow,
    output logic [15:0]         out_quot,
    output logic [DW-1:0]       out_den,
    output logic [15:0]         out_bear,
    output logic                out_sat,
    output logic                out_zero
);

    logic          valid_reg;
    logic [DW:0]   rem_reg;
    logic [15:0]   nlow_reg, quot_reg, bear_reg;
    logic [DW-1:0] den_reg;
    logic          sat_reg, zero_reg;
    logic [DW:0]   trial;
    logic [DW:0]   rem_next;
    logic [15:0]   quot_next;

    // Shift in the next numerator bit, then compare and subtract.
    always_comb
    begin
        trial = {in_rem[DW-1:0], in_nlow[15]};
        if (trial >= {1'b0, in_den})
        begin
            rem_next  = trial - {1'b0, in_den};
            quot_next = {in_quot[14:0], 1'b1};
        end
        else
        begin
            rem_next  = trial;
            quot_next = {in_quot[14:0], 1'b0};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            nlow_reg <= {in_nlow[14:0], 1'b0};
            quot_reg <= quot_next;
            den_reg  <= in_den;
            bear_reg <= in_bear;
            sat_reg  <= in_sat;
            zero_reg <= in_zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_nlow  = nlow_reg;
    assign out_quot  = quot_reg;
    assign out_den   = den_reg;
    assign out_bear  = bear_reg;
    assign out_sat   = sat_reg;
    assign out_zero  = zero_reg;

endmodule
`default_nettype wire

// File: hdl/centered_cartesian_to_polar.sv
// Top level: maps a point to normalized distance and clockwise bearing about the frame center.
//
//  Channel   Direction  Payload (low bits first)            Handshake
//  s_*       in         point_x[15:0], point_y[31:16]       s_tvalid / s_tready
//  m_*       out        norm_distance[15:0], bearing[31:16] m_tvalid / m_tready
//  cfg_*     in         0 frame_width, 1 frame_height       cfg_we (no wait)
//
// One item per cycle is sustained while m_tready stays high; the stages are one input
// stage, one CORDIC cell per stage, one normalization stage and sixteen divider cells.
// Reset clears every stage's valid bit and restores frame size 640 x 480.
// Each stage holds its item while the next one is full and stalled, so a stall at
// m_tready fills the chain from the end and s_tready falls only when all stages are full.
`default_nettype none
module centered_cartesian_to_polar #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_BITS      = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // point_x[15:0], point_y[31:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // norm_distance[15:0], bearing[31:16]
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_wdata
);

    localparam int F    = COORD_FRAC_BITS;
    localparam int S    = CORDIC_STAGES;
    localparam int AB   = ANGLE_BITS;
    localparam int CXW  = cctp_pkg::CFG_BITS + F;
    localparam int MAGB = (CXW > 17) ? CXW : 17;
    localparam int DW   = MAGB + 3;
    localparam int NW   = DW + 16;

    // Configuration registers.
    logic [12:0] frame_width_reg, frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= cctp_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= cctp_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cctp_pkg::CFG_IDX_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                cctp_pkg::CFG_IDX_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamped frame size and the half-diagonal in offset units.
    logic [12:0]          w_clamp, h_clamp;
    logic signed [DW-1:0] cx, cy, dx, dy;

    always_comb
    begin
        if (frame_width_reg < cctp_pkg::FRAME_SIZE_MIN)
            w_clamp = cctp_pkg::FRAME_SIZE_MIN;
        else if (frame_width_reg > cctp_pkg::FRAME_SIZE_MAX)
            w_clamp = cctp_pkg::FRAME_SIZE_MAX;
        else
            w_clamp = frame_width_reg;
        if (frame_height_reg < cctp_pkg::FRAME_SIZE_MIN)
            h_clamp = cctp_pkg::FRAME_SIZE_MIN;
        else if (frame_height_reg > cctp_pkg::FRAME_SIZE_MAX)
            h_clamp = cctp_pkg::FRAME_SIZE_MAX;
        else
            h_clamp = frame_height_reg;
        cx = DW'({w_clamp, {F{1'b0}}});
        cy = DW'({h_clamp, {F{1'b0}}});
        dx = DW'({s_tdata[15:0], 1'b0}) - cx;
        dy = DW'({s_tdata[31:16], 1'b0}) - cy;
    end

    // Chain wiring between cells.
    logic                 cv   [0:S];
    logic                 cr   [0:S];
    logic signed [DW-1:0] cxx  [0:S];
    logic signed [DW-1:0] cyy  [0:S];
    logic        [AB-1:0] czz  [0:S];
    logic signed [DW-1:0] cxc  [0:S];
    logic signed [DW-1:0] cyc  [0:S];
    logic                 czr  [0:S];

    // Input stage: center offset and half-turn pre-rotation of the left half plane.
    logic                 in_valid_reg;
    logic signed [DW-1:0] in_x_reg, in_y_reg, in_xc_reg, in_yc_reg;
    logic        [AB-1:0] in_z_reg;
    logic                 in_zero_reg;

    assign s_tready = !in_valid_reg || cr[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            if (dx[DW-1])
            begin
                in_x_reg <= -dx;
                in_y_reg <= -dy;
                in_z_reg <= {1'b1, {(AB-1){1'b0}}};
            end
            else
            begin
                in_x_reg <= dx;
                in_y_reg <= dy;
                in_z_reg <= '0;
            end
            in_xc_reg   <= cx;
            in_yc_reg   <= cy;
            in_zero_reg <= (dx == '0) && (dy == '0);
        end
    end

    assign cv[0]  = in_valid_reg;
    assign cxx[0] = in_x_reg;
    assign cyy[0] = in_y_reg;
    assign czz[0] = in_z_reg;
    assign cxc[0] = in_xc_reg;
    assign cyc[0] = in_yc_reg;
    assign czr[0] = in_zero_reg;

    // Row of CORDIC cells.
    for (genvar i = 0; i < S; i++)
    begin : g_cordic
        cctp_cordic_cell #(
            .IDX (i),
            .DW  (DW),
            .AB  (AB)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_x      (cxx[i]),
            .in_y      (cyy[i]),
            .in_z      (czz[i]),
            .in_xc     (cxc[i]),
            .in_yc     (cyc[i]),
            .in_zero   (czr[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_x     (cxx[i+1]),
            .out_y     (cyy[i+1]),
            .out_z     (czz[i+1]),
            .out_xc    (cxc[i+1]),
            .out_yc    (cyc[i+1]),
            .out_zero  (czr[i+1])
        );
    end

    // Normalization stage: numerator, saturation test and bearing.
    logic [DW-1:0] md, mc;
    logic [NW-1:0] numer;
    logic [AB-1:0] neg_z;
    logic [15:0]   bear16;

    always_comb
    begin
        md    = cxx[S][DW-1] ? '0 : cxx[S];
        mc    = (cxc[S][DW-1] || cxc[S] == '0) ? DW'(1) : cxc[S];
        numer = {md, 16'h0000} - NW'(md) + NW'(mc >> 1);
        neg_z = '0 - czz[S];
    end

    if (AB >= 16)
    begin : g_bear_top
        assign bear16 = neg_z[AB-1 -: 16];
    end
    else
    begin : g_bear_pad
        assign bear16 = {neg_z, {(16-AB){1'b0}}};
    end

    logic          dv   [0:16];
    logic          dr   [0:16];
    logic [DW:0]   drem [0:16];
    logic [15:0]   dnl  [0:16];
    logic [15:0]   dq   [0:16];
    logic [DW-1:0] dden [0:16];
    logic [15:0]   dbr  [0:16];
    logic          dsat [0:16];
    logic          dzr  [0:16];

    logic          nm_valid_reg;
    logic [DW:0]   nm_rem_reg;
    logic [15:0]   nm_nlow_reg, nm_bear_reg;
    logic [DW-1:0] nm_den_reg;
    logic          nm_sat_reg, nm_zero_reg;

    assign cr[S] = !nm_valid_reg || dr[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_valid_reg <= 1'b0;
        end
        else if (cr[S])
        begin
            nm_valid_reg <= cv[S];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cr[S] && cv[S])
        begin
            nm_rem_reg  <= {1'b0, numer[NW-1:16]};
            nm_nlow_reg <= numer[15:0];
            nm_den_reg  <= mc;
            nm_sat_reg  <= (md >= mc);
            nm_zero_reg <= czr[S];
            nm_bear_reg <= bear16;
        end
    end

    assign dv[0]   = nm_valid_reg;
    assign drem[0] = nm_rem_reg;
    assign dnl[0]  = nm_nlow_reg;
    assign dq[0]   = 16'h0000;
    assign dden[0] = nm_den_reg;
    assign dbr[0]  = nm_bear_reg;
    assign dsat[0] = nm_sat_reg;
    assign dzr[0]  = nm_zero_reg;

    // Row of divider cells, one quotient bit each.
    for (genvar k = 0; k < 16; k++)
    begin : g_div
        cctp_div_cell #(
            .DW (DW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv[k]),
            .in_ready  (dr[k]),
            .in_rem    (drem[k]),
            .in_nlow   (dnl[k]),
            .in_quot   (dq[k]),
            .in_den    (dden[k]),
            .in_bear   (dbr[k]),
            .in_sat    (dsat[k]),
            .in_zero   (dzr[k]),
            .out_valid (dv[k+1]),
            .out_ready (dr[k+1]),
            .out_rem   (drem[k+1]),
            .out_nlow  (dnl[k+1]),
            .out_quot  (dq[k+1]),
            .out_den   (dden[k+1]),
            .out_bear  (dbr[k+1]),
            .out_sat   (dsat[k+1]),
            .out_zero  (dzr[k+1])
        );
    end

    // Result: the last divider cell serves as the output register.
    logic [15:0] norm_dist;

    always_comb
    begin
        if (dzr[16])
            norm_dist = 16'h0000;
        else if (dsat[16])
            norm_dist = 16'hFFFF;
        else
            norm_dist = dq[16];
    end

    assign dr[16]   = m_tready;
    assign m_tvalid = dv[16];
    assign m_tdata  = {(dzr[16] ? 16'h0000 : dbr[16]), norm_dist};

endmodule
`default_nettype wire

// File: verif/centered_cartesian_to_polar_checker.sv
// Checker that predicts distance and bearing for each accepted point and compares results.
`timescale 1ns / 1ps
module centered_cartesian_to_polar_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // point_x[15:0], point_y[31:16]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // norm_distance[15:0], bearing[31:16]
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_wdata,
    output int               fail_count,
    output int               pending,
    output int               results_seen
);

    typedef struct packed {
        logic [15:0] norm_distance;
        logic [15:0] bearing;
    } polar_t;

    localparam int FRAC   = 4;
    localparam int STAGES = 16;

    // atan(2^-i) in 2^-32 turn units for the stages used here.
    localparam logic [31:0] ARCTAN [STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    polar_t      polar_q[$];

    // Frame sizes outside the legal range saturate to its bounds.
    function automatic longint size_limit(input logic [12:0] v);
        if (v < cctp_pkg::FRAME_SIZE_MIN) return longint'(cctp_pkg::FRAME_SIZE_MIN);
        if (v > cctp_pkg::FRAME_SIZE_MAX) return longint'(cctp_pkg::FRAME_SIZE_MAX);
        return longint'(v);
    endfunction

    // Vectoring rotations: returns the gain-scaled length and the angle in 2^-16 turn.
    function automatic longint vector_length(input longint xi, input longint yi,
                                             output logic [15:0] ang);
        longint x;
        longint y;
        longint xs;
        longint ys;
        logic [15:0] z;
        logic [15:0] step;
        x = xi;
        y = yi;
        z = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 16'h8000;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs   = x >>> i;
            ys   = y >>> i;
            step = 16'((64'(ARCTAN[i]) + 64'h8000) >> 16);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + step;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - step;
            end
        end
        ang = z;
        return x;
    endfunction

    function automatic polar_t polar_of(input logic [15:0] px, input logic [15:0] py);
        polar_t      r;
        longint      cx;
        longint      cy;
        longint      dx;
        longint      dy;
        longint      md;
        longint      mc;
        longint      q;
        logic [15:0] z;
        logic [15:0] zc;
        cx = size_limit(width_reg) << FRAC;
        cy = size_limit(height_reg) << FRAC;
        dx = 2 * longint'(px) - cx;
        dy = 2 * longint'(py) - cy;
        r  = '0;
        if (dx != 0 || dy != 0)
        begin
            md = vector_length(dx, dy, z);
            mc = vector_length(cx, cy, zc);
            if (md < 0) md = 0;
            if (mc < 1) mc = 1;
            q = (md * 65535 + mc / 2) / mc;
            r.norm_distance = (q > 65535) ? 16'hFFFF : 16'(q);
            r.bearing       = -z;
        end
        return r;
    endfunction

    // Track configuration, queue predictions, and compare results.
    always @(posedge clk or negedge rst_n)
    begin
        polar_t exp_r;
        if (!rst_n)
        begin
            width_reg  <= cctp_pkg::FRAME_WIDTH_RESET;
            height_reg <= cctp_pkg::FRAME_HEIGHT_RESET;
            polar_q.delete();
            fail_count   <= 0;
            results_seen <= 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == cctp_pkg::CFG_IDX_FRAME_WIDTH)
                    width_reg <= cfg_wdata;
                else
                    height_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready)
                polar_q.push_back(polar_of(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (polar_q.size() == 0)
                begin
                    $error("result with nothing expected: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = polar_q.pop_front();
                    if (m_tdata[15:0] !== exp_r.norm_distance)
                    begin
                        $error("norm_distance expected %0d actual %0d",
                               exp_r.norm_distance, m_tdata[15:0]);
                        fail_count <= fail_count + 1;
                    end
                    if (m_tdata[31:16] !== exp_r.bearing)
                    begin
                        $error("bearing expected %0d actual %0d",
                               exp_r.bearing, m_tdata[31:16]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= polar_q.size();
        end
    end

endmodule

// File: verif/centered_cartesian_to_polar_test.sv
// Testbench top: clock, reset, point stimulus, frame size phases and the verdict.
`timescale 1ns / 1ps
module centered_cartesian_to_polar_test;

    localparam int LATENCY     = 34;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 220;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          cycles;
    int          points_sent;
    bit          calm;
    bit          hold_req;
    int          eff_w;
    int          eff_h;

    centered_cartesian_to_polar u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    centered_cartesian_to_polar_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up if the run does not finish in time.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, or a long hold-off when asked.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                for (int n = 0; n < 300; n++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
        end
    end

    // Offer one point and wait until it is taken; the caller sits at a falling edge.
    task automatic send_point(input logic [15:0] px, input logic [15:0] py);
        if (!calm && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        points_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Write both frame size registers while the block is idle.
    task automatic set_frame(input logic [12:0] fw, input logic [12:0] fh);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= cctp_pkg::CFG_IDX_FRAME_WIDTH;
        cfg_wdata <= fw;
        @(negedge clk);
        cfg_index <= cctp_pkg::CFG_IDX_FRAME_HEIGHT;
        cfg_wdata <= fh;
        @(negedge clk);
        cfg_we <= 1'b0;
        eff_w = (fw < 2) ? 2 : (fw > 4096) ? 4096 : fw;
        eff_h = (fh < 2) ? 2 : (fh > 4096) ? 4096 : fh;
    endtask

    // Mostly points near the frame, some anywhere, a few exactly at the center.
    task automatic random_point();
        int r;
        int sx;
        int sy;
        r  = $urandom_range(19);
        sx = (eff_w * 32 > 65535) ? 65535 : eff_w * 32;
        sy = (eff_h * 32 > 65535) ? 65535 : eff_h * 32;
        if (r == 0)
            send_point(16'(eff_w * 8), 16'(eff_h * 8));
        else if (r < 14)
            send_point(16'($urandom_range(sx)), 16'($urandom_range(sy)));
        else
            send_point(16'($urandom), 16'($urandom));
    endtask

    logic [12:0] frame_w [8] = '{13'd640, 13'd2, 13'd4096, 13'd0, 13'd8191,
                                 13'd3, 13'd1920, 13'd1};
    logic [12:0] frame_h [8] = '{13'd480, 13'd2, 13'd4096, 13'd1, 13'd4097,
                                 13'd5, 13'd1080, 13'd4095};

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_index   = cctp_pkg::CFG_IDX_FRAME_WIDTH;
        cfg_wdata   = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        points_sent = 0;
        eff_w       = 640;
        eff_h       = 480;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed points at the reset frame size: corners, axes, center, far away.
        send_point(16'd0, 16'd0);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'd0, 16'hFFFF);
        send_point(16'hFFFF, 16'd0);
        send_point(16'd5120, 16'd3840);
        send_point(16'd5121, 16'd3840);
        send_point(16'd5119, 16'd3840);
        send_point(16'd5120, 16'd3841);
        send_point(16'd5120, 16'd3839);
        send_point(16'd0, 16'd3840);
        send_point(16'd10240, 16'd3840);
        send_point(16'd5120, 16'd0);
        send_point(16'd10240, 16'd7680);
        send_point(16'd0, 16'd7680);
        send_point(16'd2000, 16'd6000);
        send_point(16'hAAAA, 16'h5555);
        send_point(16'h5555, 16'hAAAA);

        // Frame size phases, extremes and out-of-range values among them.
        for (int p = 0; p < 8; p++)
        begin
            if (p > 0)
                set_frame(frame_w[p], frame_h[p]);
            send_point(16'(eff_w * 8), 16'(eff_h * 8));
            calm = (p == 2);
            if (p == 1)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 3 && k == PHASE_ITEMS / 2)
                begin
                    s_tvalid <= 1'b0;
                    while (pending != 0) @(negedge clk);
                end
                random_point();
            end
        end
        calm = 1'b0;

        // Let the pipeline empty out, then report.
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        $display("Sent %0d points over 8 frame sizes, checked %0d results in %0d cycles.",
                 points_sent, results_seen, cycles);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
